FILE: hdl/lit_esc_pkg.sv
// Package for the string literal escape decoder.
// Holds the character classification record, the decode mode codes of the back end
// (decode) and the helpers used by the front end (classify). No dependencies.
package lit_esc_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOWER_O = 8'h6F;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] HEX_LETTER_BASE = 8'd10;

    localparam logic [7:0] CH_LOWER_B = 8'h62;
    localparam logic [7:0] CH_LOWER_T = 8'h74;
    localparam logic [7:0] CH_LOWER_N = 8'h6E;
    localparam logic [7:0] CH_LOWER_V = 8'h76;
    localparam logic [7:0] CH_LOWER_FF = 8'h66;
    localparam logic [7:0] CH_LOWER_R = 8'h72;

    localparam logic [7:0] CODE_BELL = 8'd7;
    localparam logic [7:0] CODE_BACKSPACE = 8'd8;
    localparam logic [7:0] CODE_TAB = 8'd9;
    localparam logic [7:0] CODE_NEWLINE = 8'd10;
    localparam logic [7:0] CODE_VTAB = 8'd11;
    localparam logic [7:0] CODE_FORMFEED = 8'd12;
    localparam logic [7:0] CODE_RETURN = 8'd13;

    localparam logic [2:0] MODE_PLAIN = 3'd0;
    localparam logic [2:0] MODE_ESCAPE = 3'd1;
    localparam logic [2:0] MODE_OCTAL = 3'd2;
    localparam logic [2:0] MODE_HEX = 3'd3;
    localparam logic [2:0] MODE_DISCARD = 3'd4;

    localparam logic [1:0] OCT_DIGITS = 2'd3;
    localparam logic [1:0] HEX_DIGITS = 2'd2;

    // One classified character, as queued between front and back.
    typedef struct packed {
        logic [7:0] raw;
        logic       last;
        logic       is_bslash;
        logic       is_o;
        logic       is_x;
        logic       oct_ok;
        logic       hex_ok;
        logic [3:0] digit;
        logic [7:0] ctrl;
    } t_cls;

    function automatic logic [7:0] control_code(input logic [7:0] c);
        logic [7:0] code;
        begin
            unique case (c)
                CH_LOWER_A: code = CODE_BELL;
                CH_LOWER_B: code = CODE_BACKSPACE;
                CH_LOWER_T: code = CODE_TAB;
                CH_LOWER_N: code = CODE_NEWLINE;
                CH_LOWER_V: code = CODE_VTAB;
                CH_LOWER_FF: code = CODE_FORMFEED;
                CH_LOWER_R: code = CODE_RETURN;
                default: code = c;
            endcase
            return code;
        end
    endfunction

    function automatic t_cls classify(input logic [7:0] c, input logic last);
        t_cls       r;
        logic       is_dec;
        logic       is_up;
        logic       is_lo;
        logic [7:0] val;
        begin
            is_dec = (c >= CH_ZERO) && (c <= CH_NINE);
            is_up = (c >= CH_UPPER_A) && (c <= CH_UPPER_F);
            is_lo = (c >= CH_LOWER_A) && (c <= CH_LOWER_F);
            if (is_up) begin
                val = c - CH_UPPER_A + HEX_LETTER_BASE;
            end else if (is_lo) begin
                val = c - CH_LOWER_A + HEX_LETTER_BASE;
            end else begin
                val = c - CH_ZERO;
            end
            r.raw = c;
            r.last = last;
            r.is_bslash = (c == CH_BSLASH);
            r.is_o = (c == CH_LOWER_O);
            r.is_x = (c == CH_LOWER_X);
            r.oct_ok = (c >= CH_ZERO) && (c <= CH_SEVEN);
            r.hex_ok = is_dec || is_up || is_lo;
            r.digit = val[3:0];
            r.ctrl = control_code(c);
            return r;
        end
    endfunction

endpackage

FILE: hdl/lit_esc_front.sv
// Front end of the escape decoder: takes input requests and classifies each character.
// Depends on lit_esc_pkg; feeds lit_esc_fifo.
module lit_esc_front
    import lit_esc_pkg::*;
(
    input  logic       i_valid,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_string,
    input  logic       i_full,
    output logic       o_stall,
    output logic       o_push,
    output t_cls       o_cls
);

    // Hold off the sender while the queue has no room.
    assign o_stall = i_full;
    assign o_push = i_valid && !i_full;
    assign o_cls = classify(i_in_byte, i_end_of_string);

endmodule

FILE: hdl/lit_esc_fifo.sv
// Short queue of classified characters between front and back.
// Depends on lit_esc_pkg for the entry type.
module lit_esc_fifo
    import lit_esc_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cls i_data,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cls o_data
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_cls          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr_ptr;
    logic [PW-1:0] n_rd_ptr;
    logic [CW-1:0] n_count;
    logic          push_ok;
    logic          pop_ok;

    assign o_full = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data = r_mem[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count = r_count;
        if (push_ok) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop_ok) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count above depth");

    a_count_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == CW'(DEPTH)) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");

    a_pop_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop_ok && !push_ok) |=> (r_count == $past(r_count) - 1'b1))
        else $error("pop did not reduce count");
`endif

endmodule

FILE: hdl/lit_esc_back.sv
// Back end of the escape decoder: runs the decode state machine on queued characters
// and holds each result in an output register. Depends on lit_esc_pkg.
module lit_esc_back
    import lit_esc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_cls       i_cls,
    output logic       o_pop,
    input  logic       i_stall,
    output logic       o_valid,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_escape_error,
    output logic       o_last_out
);

    logic [2:0] r_mode;
    logic [1:0] r_digits;
    logic [7:0] r_acc;
    logic       r_ovalid;
    logic [7:0] r_obyte;
    logic       r_obvalid;
    logic       r_oerr;
    logic       r_olast;

    logic [2:0] n_mode;
    logic [1:0] n_digits;
    logic [7:0] n_acc;
    logic       res;
    logic [7:0] res_byte;
    logic       err;
    logic       is_oct;
    logic       dig_ok;
    logic [1:0] need;

    // Advance when a character waits and the output register is free or draining.
    assign o_pop = !i_empty && (!r_ovalid || !i_stall);

    always_comb begin
        n_mode = r_mode;
        n_digits = r_digits;
        n_acc = r_acc;
        res = 1'b0;
        res_byte = i_cls.raw;
        err = 1'b0;
        is_oct = (r_mode == MODE_OCTAL);
        dig_ok = is_oct ? i_cls.oct_ok : i_cls.hex_ok;
        need = is_oct ? OCT_DIGITS : HEX_DIGITS;
        unique case (r_mode) inside
            MODE_ESCAPE: begin
                if (i_cls.is_o || i_cls.is_x) begin
                    n_mode = i_cls.is_o ? MODE_OCTAL : MODE_HEX;
                    n_digits = '0;
                    n_acc = '0;
                    err = i_cls.last;
                end else begin
                    n_mode = MODE_PLAIN;
                    res = 1'b1;
                    res_byte = i_cls.ctrl;
                end
            end
            MODE_OCTAL, MODE_HEX: begin
                if (!dig_ok) begin
                    err = 1'b1;
                end else begin
                    n_acc = is_oct ? {r_acc[4:0], i_cls.digit[2:0]}
                                   : {r_acc[3:0], i_cls.digit};
                    n_digits = r_digits + 1'b1;
                    if (n_digits >= need) begin
                        res = 1'b1;
                        res_byte = n_acc;
                        n_mode = MODE_PLAIN;
                        n_digits = '0;
                        n_acc = '0;
                    end else begin
                        err = i_cls.last;
                    end
                end
            end
            MODE_DISCARD: begin
                err = i_cls.last;
            end
            default: begin
                if (i_cls.is_bslash) begin
                    n_mode = MODE_ESCAPE;
                    err = i_cls.last;
                end else begin
                    n_mode = MODE_PLAIN;
                    res = 1'b1;
                end
            end
        endcase
        if (err) begin
            n_mode = MODE_DISCARD;
            n_digits = '0;
            n_acc = '0;
        end
        // Drop all escape state at the end of a literal.
        if (i_cls.last) begin
            n_mode = MODE_PLAIN;
            n_digits = '0;
            n_acc = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_PLAIN;
            r_digits <= '0;
            r_acc <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_mode <= n_mode;
                r_digits <= n_digits;
                r_acc <= n_acc;
                r_ovalid <= res || err;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_obyte <= err ? 8'd0 : res_byte;
            r_obvalid <= !err;
            r_oerr <= err;
            r_olast <= i_cls.last;
        end
    end

    assign o_valid = r_ovalid;
    assign o_out_byte = r_obyte;
    assign o_byte_valid = r_obvalid;
    assign o_escape_error = r_oerr;
    assign o_last_out = r_olast;

`ifndef ASSERT_OFF
    a_mode_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode <= MODE_DISCARD)
        else $error("decode mode out of range");

    a_digits_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_digits < OCT_DIGITS)
        else $error("digit count reached a full escape without clearing");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_cls.last) |=> (r_mode == MODE_PLAIN && r_digits == '0 && r_acc == '0))
        else $error("state not cleared after final character");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_cls.last) |=> (r_ovalid && r_olast))
        else $error("final character gave no result");

    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_oerr) |-> (!r_obvalid && r_obyte == 8'd0))
        else $error("error result carries a character");
`endif

endmodule

FILE: hdl/literal_escape_decoder_top.sv
// String literal escape decoder: one byte in per cycle, at most one result per byte.
// An input byte is written into the queue, then decoded into the output register.
// Throughput: 1 byte per cycle while the queue has room and the output does not stall.
// Both sides stall on their own; the queue absorbs up to DEPTH bytes of output stall.
// Reset (i_rst_n low, synchronous) empties the queue, drops any pending result and
// returns the decoder to plain text mode; the block takes input as soon as reset is released.
module literal_escape_decoder_top
    import lit_esc_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_string,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_escape_error,
    output logic       o_last_out
);

    t_cls front_cls;
    t_cls queue_cls;
    logic push;
    logic pop;
    logic full;
    logic empty;

    lit_esc_front u_front (
        .i_valid         (i_in_valid),
        .i_in_byte       (i_in_byte),
        .i_end_of_string (i_end_of_string),
        .i_full          (full),
        .o_stall         (o_in_stall),
        .o_push          (push),
        .o_cls           (front_cls)
    );

    lit_esc_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cls),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_data  (queue_cls)
    );

    lit_esc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_cls          (queue_cls),
        .o_pop          (pop),
        .i_stall        (i_out_stall),
        .o_valid        (o_out_valid),
        .o_out_byte     (o_out_byte),
        .o_byte_valid   (o_byte_valid),
        .o_escape_error (o_escape_error),
        .o_last_out     (o_last_out)
    );

endmodule
